// File: rtl/gtg_pkg.sv
// package for the go-to-goal controller: constants, atan table
// no dependencies
package gtg_pkg;

  localparam int CordicStagesDef = 16;
  localparam int AngW = 36;

  localparam logic signed [AngW-1:0] AngPi = 36'sd3373259426;
  localparam logic signed [AngW-1:0] AngTwoPi = 36'sd6746518851;
  localparam logic signed [AngW-1:0] HeadTol = 36'sd18253611;
  localparam logic [29:0] CordicGain = 30'd652032874;

  localparam logic [2:0] AddrGoalX = 3'd0;
  localparam logic [2:0] AddrGoalY = 3'd1;
  localparam logic [2:0] AddrGoalHd = 3'd2;
  localparam logic [2:0] AddrTol = 3'd3;
  localparam logic [2:0] AddrGainD = 3'd4;
  localparam logic [2:0] AddrGainA = 3'd5;

  localparam logic [1:0] PhaseDrive = 2'd0;
  localparam logic [1:0] PhaseRotate = 2'd1;
  localparam logic [1:0] PhaseReached = 2'd2;

  function automatic logic signed [AngW-1:0] atan_val(input logic [4:0] i);
    logic signed [AngW-1:0] r;
    begin
      case (i)
        5'd0: r = 36'sd843314857;
        5'd1: r = 36'sd497837829;
        5'd2: r = 36'sd263043837;
        5'd3: r = 36'sd133525159;
        5'd4: r = 36'sd67021687;
        5'd5: r = 36'sd33543516;
        5'd6: r = 36'sd16775851;
        5'd7: r = 36'sd8388437;
        5'd8: r = 36'sd4194283;
        5'd9: r = 36'sd2097149;
        5'd31: r = '0;
        default: r = 36'sd1 <<< (5'd30 - i);
      endcase
      return r;
    end
  endfunction

  // one wrap step; inputs stay within a few multiples of pi
  function automatic logic signed [AngW-1:0] wrap1(input logic signed [AngW-1:0] a);
    begin
      if (a > AngPi) return a - AngTwoPi;
      else if (a < -AngPi) return a + AngTwoPi;
      else return a;
    end
  endfunction

endpackage

// File: rtl/go_to_goal_p_controller_top.sv
// go-to-goal proportional controller, top level
// depends on gtg_pkg
//
// Use: an APB-style port writes the goal pose, tolerance and gains while the
// block is idle. Pose requests enter on pose_* with valid/ready; one
// command request leaves on linear_speed/turn_rate/phase/goal_reached.
// The datapath is a pipeline: an input stage, CORDIC_STAGES vectoring stages,
// and five output stages (distance scaling multiply, angle wrap, phase
// decision with speed multiply, turn multiply, saturate into the output
// register). One request is taken every cycle unless the output stage
// holds an untaken result. The whole pipeline advances together; when the
// receiver stalls with a valid result waiting, every stage holds and ready
// drops only if the output stage is full. Reset (rst, synchronous) clears all
// valid bits and loads the register defaults: goal 0, tolerance 6554,
// both gains 256.
module go_to_goal_p_controller_top #(
  parameter int CORDIC_STAGES = gtg_pkg::CordicStagesDef
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] pose_x,
  input  logic signed [31:0] pose_y,
  input  logic signed [15:0] pose_heading,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] linear_speed,
  output logic signed [31:0] turn_rate,
  output logic [1:0]         phase,
  output logic               goal_reached
);
  localparam int AW = gtg_pkg::AngW;
  localparam int XW = 36;
  localparam int NS = CORDIC_STAGES + 1;

  logic signed [31:0] goal_pos_x, goal_pos_y;
  logic signed [15:0] goal_heading;
  logic [30:0] position_tolerance;
  logic [15:0] gain_distance, gain_angle;

  // register writes
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      goal_pos_x <= '0;
      goal_pos_y <= '0;
      goal_heading <= '0;
      position_tolerance <= 31'd6554;
      gain_distance <= 16'd256;
      gain_angle <= 16'd256;
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        gtg_pkg::AddrGoalX: goal_pos_x <= pwdata;
        gtg_pkg::AddrGoalY: goal_pos_y <= pwdata;
        gtg_pkg::AddrGoalHd: goal_heading <= pwdata[15:0];
        gtg_pkg::AddrTol: position_tolerance <= pwdata[30:0];
        gtg_pkg::AddrGainD: gain_distance <= pwdata[15:0];
        gtg_pkg::AddrGainA: gain_angle <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[4:2])
      gtg_pkg::AddrGoalX: prdata = goal_pos_x;
      gtg_pkg::AddrGoalY: prdata = goal_pos_y;
      gtg_pkg::AddrGoalHd: prdata = {{16{goal_heading[15]}}, goal_heading};
      gtg_pkg::AddrTol: prdata = {1'b0, position_tolerance};
      gtg_pkg::AddrGainD: prdata = {16'd0, gain_distance};
      gtg_pkg::AddrGainA: prdata = {16'd0, gain_angle};
      default: prdata = '0;
    endcase
  end

  // global advance: stall only when the output holds an untaken result
  logic adv;
  assign adv = !out_valid || out_ready;
  assign in_ready = adv;

  // cordic stage registers, index 0 is the input stage
  logic              cv [NS];
  logic signed [XW-1:0] cx [NS];
  logic signed [XW-1:0] cy [NS];
  logic signed [AW-1:0] cz [NS];
  logic signed [AW-1:0] chd [NS];

  // input stage: differences and half-plane fold
  logic signed [32:0] dx0, dy0;
  assign dx0 = 33'(goal_pos_x) - 33'(pose_x);
  assign dy0 = 33'(goal_pos_y) - 33'(pose_y);
  always_ff @(posedge clk) begin
    if (rst) cv[0] <= 1'b0;
    else if (adv) cv[0] <= in_valid;
    if (adv) begin
      chd[0] <= AW'(pose_heading) <<< 17;
      if (dx0 < 0) begin
        cx[0] <= -XW'(dx0);
        cy[0] <= -XW'(dy0);
        cz[0] <= (dy0 >= 0) ? gtg_pkg::AngPi : -gtg_pkg::AngPi;
      end else begin
        cx[0] <= XW'(dx0);
        cy[0] <= XW'(dy0);
        cz[0] <= '0;
      end
    end
  end

  // vectoring iterations, one per stage
  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cordic
    logic signed [XW-1:0] xs, ys;
    assign xs = cx[g] >>> g;
    assign ys = cy[g] >>> g;
    always_ff @(posedge clk) begin
      if (rst) cv[g+1] <= 1'b0;
      else if (adv) cv[g+1] <= cv[g];
      if (adv) begin
        chd[g+1] <= chd[g];
        if (cy[g] >= 0) begin
          cx[g+1] <= cx[g] + ys;
          cy[g+1] <= cy[g] - xs;
          cz[g+1] <= cz[g] + gtg_pkg::atan_val(5'(g));
        end else begin
          cx[g+1] <= cx[g] - ys;
          cy[g+1] <= cy[g] + xs;
          cz[g+1] <= cz[g] - gtg_pkg::atan_val(5'(g));
        end
      end
    end
  end

  // p1: distance scaling multiply, raw errors
  logic p1v;
  logic [65:0] p1_dprod;
  logic signed [AW-1:0] p1_berr, p1_herr;
  always_ff @(posedge clk) begin
    if (rst) p1v <= 1'b0;
    else if (adv) p1v <= cv[NS-1];
    if (adv) begin
      p1_dprod <= 66'(unsigned'(cx[NS-1])) * 66'(gtg_pkg::CordicGain) + (66'd1 << 29);
      p1_berr <= cz[NS-1] - chd[NS-1];
      p1_herr <= (AW'(goal_heading) <<< 17) - chd[NS-1];
    end
  end

  // p2: distance, wrap angle errors
  logic p2v;
  logic [35:0] p2_dist;
  logic signed [AW-1:0] p2_berr, p2_herr;
  always_ff @(posedge clk) begin
    if (rst) p2v <= 1'b0;
    else if (adv) p2v <= p1v;
    if (adv) begin
      p2_dist <= p1_dprod[65:30];
      p2_berr <= gtg_pkg::wrap1(gtg_pkg::wrap1(p1_berr));
      p2_herr <= gtg_pkg::wrap1(gtg_pkg::wrap1(p1_herr));
    end
  end

  // p3: phase decision and selected error, speed multiply
  logic p3v;
  logic [1:0] p3_phase;
  logic signed [AW-1:0] p3_err;
  logic [52:0] p3_lin;
  always_ff @(posedge clk) begin
    if (rst) p3v <= 1'b0;
    else if (adv) p3v <= p2v;
    if (adv) begin
      p3_lin <= 53'(p2_dist) * 53'(gain_distance) + 53'd128;
      if (p2_dist > 36'(position_tolerance)) begin
        p3_phase <= gtg_pkg::PhaseDrive;
        p3_err <= p2_berr;
      end else if (p2_herr > gtg_pkg::HeadTol || p2_herr < -gtg_pkg::HeadTol) begin
        p3_phase <= gtg_pkg::PhaseRotate;
        p3_err <= p2_herr;
      end else begin
        p3_phase <= gtg_pkg::PhaseReached;
        p3_err <= '0;
      end
    end
  end

  // p4: turn multiply
  logic p4v;
  logic [1:0] p4_phase;
  logic [44:0] p4_lin;
  logic signed [53:0] p4_turn;
  always_ff @(posedge clk) begin
    if (rst) p4v <= 1'b0;
    else if (adv) p4v <= p3v;
    if (adv) begin
      p4_phase <= p3_phase;
      p4_lin <= p3_lin[52:8];
      p4_turn <= 54'(p3_err) * 54'(signed'({1'b0, gain_angle})) + (54'sd1 <<< 21);
    end
  end

  // output stage: shift, saturate, zero by phase
  logic signed [31:0] turn_sh;
  logic signed [31:0] lin_sat;
  logic signed [31:0] p4_tq;
  assign p4_tq = 32'(p4_turn >>> 22);
  always_comb begin
    if ((p4_turn >>> 22) > 54'sd2147483647) turn_sh = 32'sh7fffffff;
    else if ((p4_turn >>> 22) < -54'sd2147483648) turn_sh = 32'sh80000000;
    else turn_sh = p4_tq;
    lin_sat = (p4_lin > 45'd2147483647) ? 32'sh7fffffff : 32'(p4_lin);
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (adv) out_valid <= p4v;
    if (adv) begin
      phase <= p4_phase;
      goal_reached <= (p4_phase == gtg_pkg::PhaseReached);
      linear_speed <= (p4_phase == gtg_pkg::PhaseDrive) ? lin_sat : '0;
      turn_rate <= (p4_phase == gtg_pkg::PhaseReached) ? '0 : turn_sh;
    end
  end
endmodule

// File: rtl/gtg_checker.sv
// port-level checks for the go-to-goal controller
// depends on gtg_pkg and go_to_goal_p_controller_top
module gtg_checker (
  input logic               clk,
  input logic               rst,
  input logic               pready,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] linear_speed,
  input logic signed [31:0] turn_rate,
  input logic [1:0]         phase,
  input logic               goal_reached
);
  // result held while stalled
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(linear_speed) && $stable(turn_rate)
      && $stable(phase) && $stable(goal_reached))
    else $error("result changed while stalled");
  // reached flag matches phase
  a_reach: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> goal_reached == (phase == gtg_pkg::PhaseReached))
    else $error("goal flag disagrees with phase");
  // no speed outside drive
  a_speed: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase != gtg_pkg::PhaseDrive |-> linear_speed == 0)
    else $error("speed outside drive");
  // accepts whenever output free
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready && pready)
    else $error("not ready with empty output");
endmodule

bind go_to_goal_p_controller_top gtg_checker u_gtg_checker (.*);

// File: tb/go_to_goal_p_controller_top_test.sv
// testbench for the go-to-goal proportional controller: directed table, then random poses
// checked against an in-bench predictor under varied idling and register settings
// depends on gtg_pkg and go_to_goal_p_controller_top
`timescale 1ns / 100ps

module go_to_goal_p_controller_top_test;

  localparam int Stages = gtg_pkg::CordicStagesDef;
  localparam longint LimitCycles = 400000;
  // an index with no register behind it
  localparam logic [2:0] AddrSpare = 3'd7;

  typedef struct packed {
    logic signed [31:0] speed;
    logic signed [31:0] turn;
    logic [1:0]         ph;
    logic               reached;
  } command_t;

  typedef struct {
    logic signed [31:0] px;
    logic signed [31:0] py;
    logic signed [15:0] hd;
    bit                 typed;
    command_t           cmd;
  } pose_row_t;

  logic clk = 0;
  logic rst = 1;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [4:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid = 0;
  logic in_ready;
  logic signed [31:0] pose_x = '0, pose_y = '0;
  logic signed [15:0] pose_heading = '0;
  logic out_valid;
  logic out_ready = 0;
  logic signed [31:0] linear_speed, turn_rate;
  logic [1:0] phase;
  logic goal_reached;

  // predictor copy of the registers
  longint goal_x, goal_y, goal_hd, tol, gain_d, gain_a;

  command_t expected_cmds[$];
  int mismatches = 0;
  int checked = 0;
  int sent = 0;
  longint cycles = 0;
  int send_idle = 0;
  int recv_stall = 0;
  int hold_off = 0;

  go_to_goal_p_controller_top #(.CORDIC_STAGES(Stages)) u_top (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .in_valid, .in_ready, .pose_x, .pose_y, .pose_heading,
    .out_valid, .out_ready, .linear_speed, .turn_rate, .phase, .goal_reached
  );

  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LimitCycles) begin
      $display("timeout after %0d cycles", cycles);
      $display("go_to_goal_p_controller_top: mismatch");
      $finish;
    end
  end

  function automatic longint floor_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint wrap_err(longint a);
    longint r;
    r = a;
    while (r > longint'(gtg_pkg::AngPi)) r = r - longint'(gtg_pkg::AngTwoPi);
    while (r < -longint'(gtg_pkg::AngPi)) r = r + longint'(gtg_pkg::AngTwoPi);
    return r;
  endfunction

  function automatic logic signed [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint atan_step(int i);
    longint t[10] = '{843314857, 497837829, 263043837, 133525159, 67021687,
                      33543516, 16775851, 8388437, 4194283, 2097149};
    if (i < 10) return t[i];
    if (i >= 31) return 0;
    return longint'(1) << (30 - i);
  endfunction

  function automatic logic signed [31:0] turn_of(longint err);
    return clamp32(floor_shr(gain_a * err + (longint'(1) << 21), 22));
  endfunction

  // steering command for one pose against the current goal
  function automatic command_t steer_command(logic signed [31:0] px,
                                             logic signed [31:0] py,
                                             logic signed [15:0] hd_in);
    command_t c;
    longint hd, dx, dy, x, y, z, xs, ys, herr;
    logic [63:0] range_q, lin;
    hd = longint'(hd_in) * 131072;
    dx = goal_x - longint'(px);
    dy = goal_y - longint'(py);
    x = dx; y = dy; z = 0;
    if (dx < 0) begin
      x = -dx; y = -dy;
      z = (dy >= 0) ? longint'(gtg_pkg::AngPi) : -longint'(gtg_pkg::AngPi);
    end
    for (int i = 0; i < Stages && i < 32; i++) begin
      xs = floor_shr(x, i);
      ys = floor_shr(y, i);
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + atan_step(i);
      end else begin
        x = x - ys; y = y + xs; z = z - atan_step(i);
      end
    end
    range_q = (64'(x) * 64'd652032874 + (64'd1 << 29)) >> 30;
    c = '0;
    if (range_q > 64'(tol)) begin
      lin = (64'(gain_d) * range_q + 64'd128) >> 8;
      c.speed = (lin > 64'd2147483647) ? 32'sh7fffffff : lin[31:0];
      c.turn = turn_of(wrap_err(z - hd));
      c.ph = gtg_pkg::PhaseDrive;
    end else begin
      herr = wrap_err(goal_hd * 131072 - hd);
      if (herr > longint'(gtg_pkg::HeadTol) || herr < -longint'(gtg_pkg::HeadTol)) begin
        c.turn = turn_of(herr);
        c.ph = gtg_pkg::PhaseRotate;
      end else begin
        c.ph = gtg_pkg::PhaseReached;
        c.reached = 1'b1;
      end
    end
    return c;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    $display("error at cycle %0d: %s got %0d expected %0d", cycles, what, got, want);
  endtask

  // receiver: compare each command request with the oldest expectation
  always @(posedge clk) begin
    command_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_cmds.size() == 0) begin
        report_mismatch("unexpected request", 0, 0);
      end else begin
        want = expected_cmds.pop_front();
        checked++;
        if (linear_speed !== want.speed) report_mismatch("linear_speed", linear_speed, want.speed);
        if (turn_rate !== want.turn) report_mismatch("turn_rate", turn_rate, want.turn);
        if (phase !== want.ph) report_mismatch("phase", phase, want.ph);
        if (goal_reached !== want.reached)
          report_mismatch("goal_reached", goal_reached, want.reached);
      end
    end
  end

  // receiver stalling, with an optional long hold-off counted here
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !($urandom_range(99) < recv_stall);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] value);
    @(posedge clk);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= value;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      gtg_pkg::AddrGoalX: goal_x = longint'(signed'(value));
      gtg_pkg::AddrGoalY: goal_y = longint'(signed'(value));
      gtg_pkg::AddrGoalHd: goal_hd = longint'(signed'(value[15:0]));
      gtg_pkg::AddrTol: tol = longint'(value[30:0]);
      gtg_pkg::AddrGainD: gain_d = longint'(value[15:0]);
      gtg_pkg::AddrGainA: gain_a = longint'(value[15:0]);
      default: ;
    endcase
  endtask

  // offer one pose request and wait for it to be taken
  task automatic send_pose(logic signed [31:0] px, logic signed [31:0] py,
                           logic signed [15:0] hd);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1; pose_x <= px; pose_y <= py; pose_heading <= hd;
    expected_cmds.push_back(steer_command(px, py, hd));
    sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (Stages + 12) @(posedge clk);
  endtask

  function automatic logic signed [15:0] rand_heading();
    case ($urandom_range(3))
      0: return 16'(signed'($urandom_range(51472)) - 25736);
      1: return 16'($urandom);
      2: return 16'(goal_hd + signed'($urandom_range(8)) - 4);
      default: return 16'(goal_hd);
    endcase
  endfunction

  // random pose: mostly near the goal so all three phases come up
  task automatic random_pose();
    logic signed [31:0] px, py;
    case ($urandom_range(4))
      0, 1: begin
        px = 32'(goal_x + signed'($urandom_range(400000)) - 200000);
        py = 32'(goal_y + signed'($urandom_range(400000)) - 200000);
      end
      2: begin
        px = 32'(goal_x + signed'($urandom_range(8000)) - 4000);
        py = 32'(goal_y + signed'($urandom_range(8000)) - 4000);
      end
      3: begin px = 32'(goal_x); py = 32'(goal_y); end
      default: begin px = $urandom; py = $urandom; end
    endcase
    send_pose(px, py, rand_heading());
  endtask

  initial begin
    pose_row_t rows[$];
    pose_row_t r;
    command_t zero_cmd;
    goal_x = 0; goal_y = 0; goal_hd = 0; tol = 6554; gain_d = 256; gain_a = 256;
    repeat (8) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed table; typed results only where they are obvious
    zero_cmd = '0;
    zero_cmd.ph = gtg_pkg::PhaseReached; zero_cmd.reached = 1;
    rows = '{
      '{0, 0, 0, 1, zero_cmd},
      '{100, -100, 16'sd20, 1, zero_cmd},
      '{0, 0, 16'sd25736, 0, '0},
      '{0, 0, -16'sd25736, 0, '0},
      '{0, 0, 16'sh7fff, 0, '0},
      '{0, 0, 16'sh8000, 0, '0},
      '{0, 0, 16'sd140, 0, '0},
      '{0, 0, -16'sd139, 0, '0},
      '{32'sh7fffffff, 0, 0, 0, '0},
      '{32'sh80000000, 0, 0, 0, '0},
      '{0, 32'sh7fffffff, 0, 0, '0},
      '{0, 32'sh80000000, 0, 0, '0},
      '{32'sh80000000, 32'sh80000000, 16'sd12000, 0, '0},
      '{32'sh7fffffff, 32'sh7fffffff, -16'sd12000, 0, '0},
      '{65536, 0, 0, 0, '0},
      '{65536, 65536, 16'sd25736, 0, '0},
      '{-65536, 1, 0, 0, '0},
      '{-65536, -1, 0, 0, '0},
      '{6554, 0, 0, 0, '0},
      '{6555, 0, 0, 0, '0}
    };
    foreach (rows[i]) begin
      r = rows[i];
      send_pose(r.px, r.py, r.hd);
      if (r.typed) begin
        if (steer_command(r.px, r.py, r.hd) != r.cmd)
          report_mismatch("directed row", i, 0);
      end
    end
    drain();

    // phases of register settings and idling
    for (int phs = 0; phs < 6; phs++) begin
      case (phs)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 53; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 53; end
        3: begin send_idle = 35; recv_stall = 35; end
        4: begin send_idle = 0; recv_stall = 0; end
        default: begin send_idle = 35; recv_stall = 35; end
      endcase
      case (phs)
        0: ;
        1: begin
          write_reg(gtg_pkg::AddrGainD, 32'h0000ffff);
          write_reg(gtg_pkg::AddrGainA, 32'h0000ffff);
          write_reg(gtg_pkg::AddrTol, 32'h7fffffff);
          write_reg(gtg_pkg::AddrGoalHd, 32'hffff8000);
        end
        2: begin
          write_reg(gtg_pkg::AddrGoalX, 32'h80000000);
          write_reg(gtg_pkg::AddrGoalY, 32'h7fffffff);
          write_reg(gtg_pkg::AddrTol, 32'd0);
          write_reg(gtg_pkg::AddrGainD, 32'd0);
          write_reg(gtg_pkg::AddrGainA, 32'd0);
          write_reg(gtg_pkg::AddrGoalHd, 32'd25736);
        end
        default: begin
          write_reg(gtg_pkg::AddrGoalX, $urandom);
          write_reg(gtg_pkg::AddrGoalY, $urandom);
          write_reg(gtg_pkg::AddrGoalHd, 32'(signed'($urandom_range(51472)) - 25736));
          write_reg(gtg_pkg::AddrTol, $urandom_range(200000));
          write_reg(gtg_pkg::AddrGainD, $urandom_range(65535));
          write_reg(gtg_pkg::AddrGainA, $urandom_range(65535));
          write_reg(AddrSpare, $urandom);
        end
      endcase
      if (phs == 4) hold_off <= 300;
      repeat (88) random_pose();
      drain();
    end

    $display("poses sent %0d, commands checked %0d, six register settings", sent, checked);
    $display("idling: none, sender only, receiver only, both, and a long receiver hold-off");
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("go_to_goal_p_controller_top: match");
    end else begin
      $display("go_to_goal_p_controller_top: mismatch");
    end
    $finish;
  end

endmodule
